FILE: src/pairwise_alignment_interval_extract_core_defines.svh
// Assertion macros shared by the interval extractor modules.
`ifndef PAIRWISE_ALIGNMENT_INTERVAL_EXTRACT_CORE_DEFINES_SVH
`define PAIRWISE_ALIGNMENT_INTERVAL_EXTRACT_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define PAIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define PAIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/paie_pkg.sv
// Package: widths, codes and the decoded item type of the interval extractor.
package paie_pkg;

  localparam int POS_BITS    = 32;
  localparam int TARGET_BITS = 16;
  localparam int OUT_BITS    = 32;
  localparam int TIDX_BITS   = 16;

  // queue depth, power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] ACT_HEADER = 2'd0;
  localparam logic [1:0] ACT_COLUMN = 2'd1;
  localparam logic [1:0] ACT_END    = 2'd2;

  localparam logic [1:0] STRAND_PLUS  = 2'd0;
  localparam logic [1:0] STRAND_MINUS = 2'd1;

  typedef logic [POS_BITS-1:0]    pos_t;
  typedef logic [TARGET_BITS-1:0] tgt_t;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_COLUMN = 2'd1,
    OP_END    = 2'd2
  } op_t;

  typedef struct packed {
    op_t  op;
    pos_t src_val;
    pos_t dest_val;
    tgt_t target;
    logic src_gap;
    logic dest_gap;
  } item_t;

  // Sign-extend a position and cut it to the result field width.
  function automatic logic signed [OUT_BITS-1:0] to_field(input pos_t v);
    logic signed [63:0] ext;
    ext = 64'(signed'(v));
    return ext[OUT_BITS-1:0];
  endfunction

endpackage

FILE: src/paie_if.sv
// Handshake interfaces for the input and result channels.
interface paie_in_if import paie_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [30:0] src_first;
  logic [30:0] dest_first;
  logic [30:0] dest_length;
  logic [1:0]  strand;
  logic [15:0] target;
  logic        src_gap;
  logic        dest_gap;

  modport source (output valid, action, src_first, dest_first, dest_length, strand,
                  target, src_gap, dest_gap, input ready);
  modport sink   (input valid, action, src_first, dest_first, dest_length, strand,
                  target, src_gap, dest_gap, output ready);
endinterface

interface paie_out_if import paie_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [OUT_BITS-1:0]  src_begin;
  logic signed [OUT_BITS-1:0]  src_stop;
  logic        [TIDX_BITS-1:0] target_index;
  logic signed [OUT_BITS-1:0]  dest_begin;
  logic signed [OUT_BITS-1:0]  dest_stop;

  modport source (output valid, src_begin, src_stop, target_index, dest_begin, dest_stop,
                  input ready);
  modport sink   (input valid, src_begin, src_stop, target_index, dest_begin, dest_stop,
                  output ready);
endinterface

FILE: src/pairwise_alignment_interval_extract_core.sv
// Pairwise alignment interval extractor, top level.
// Takes one transaction per clock unless stalled: a block header, an alignment column or an
// end of block, and returns the ungapped intervals of the block, at most one per transaction.
// The sustained rate without stalls is one transaction per cycle; the loop that sets it is
// the back end's position and open-interval registers, one compare and two increments per
// column. A result passes the front register, the two-entry queue and the output register.
// The front end decodes headers into zero-based or reverse-strand start positions; action
// code three is dropped there. Each side stalls on its own ready.
module pairwise_alignment_interval_extract_core import paie_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  paie_in_if.sink    in_ch,
  paie_out_if.source out_ch
);

  logic  push, q_ready, q_vld, pop;
  item_t push_item, q_item;

  paie_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready)
  );

  paie_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .q_vld     (q_vld),
    .q_item    (q_item),
    .pop       (pop)
  );

  paie_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_vld  (q_vld),
    .q_item (q_item),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

FILE: src/paie_front.sv
// Front end: accept input transactions, decode them and compute header start positions.
module paie_front import paie_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  paie_in_if.sink   in_ch,
  output logic      push,
  output item_t     push_item,
  input  logic      q_ready
);

  logic  vld_r, vld_nxt;
  item_t item_r, item_nxt;
  logic  take;
  pos_t  sf, df, dl;

  assign in_ch.ready = !vld_r || q_ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign push        = vld_r && q_ready;
  assign push_item   = item_r;

  assign sf = POS_BITS'(in_ch.src_first);
  assign df = POS_BITS'(in_ch.dest_first);
  assign dl = POS_BITS'(in_ch.dest_length);

  always_comb begin
    item_nxt          = item_r;
    item_nxt.src_gap  = in_ch.src_gap;
    item_nxt.dest_gap = in_ch.dest_gap;
    item_nxt.target   = TARGET_BITS'(in_ch.target);
    item_nxt.src_val  = sf;
    item_nxt.dest_val = df;
    unique case (in_ch.action)
      ACT_HEADER: item_nxt.op = OP_HEADER;
      ACT_COLUMN: item_nxt.op = OP_COLUMN;
      default:    item_nxt.op = OP_END;
    endcase
    // plus: both zero-based; minus: destination becomes reverse-strand index
    if (in_ch.strand == STRAND_PLUS) begin
      item_nxt.src_val  = sf - POS_BITS'(1);
      item_nxt.dest_val = df - POS_BITS'(1);
    end else if (in_ch.strand == STRAND_MINUS) begin
      item_nxt.src_val  = sf - POS_BITS'(1);
      item_nxt.dest_val = df - dl - POS_BITS'(1);
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (push) vld_nxt = 1'b0;
    // drop the unused action code here
    if (take) vld_nxt = (in_ch.action == ACT_HEADER) || (in_ch.action == ACT_COLUMN) ||
                        (in_ch.action == ACT_END);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: src/paie_queue.sv
// Short queue of decoded items between the front and back ends.
`include "pairwise_alignment_interval_extract_core_defines.svh"
module paie_queue import paie_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  q_ready,
  output logic  q_vld,
  output item_t q_item,
  input  logic  pop
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign q_ready = cnt_r < (QPTR_W+1)'(QDEPTH);
  assign q_vld   = cnt_r != '0;
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `PAIE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= (QPTR_W+1)'(QDEPTH), "queue count overflow")
  `PAIE_ASSERT_NOW(a_pop_nonempty, pop, cnt_r != '0, "pop from empty queue")

endmodule

FILE: src/paie_back.sv
// Back end: track row positions and the open interval, register closed intervals.
`include "pairwise_alignment_interval_extract_core_defines.svh"
module paie_back import paie_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_vld,
  input  item_t     q_item,
  output logic      pop,
  paie_out_if.source out_ch
);

  pos_t src_pos_r, src_pos_nxt;
  pos_t dest_pos_r, dest_pos_nxt;
  pos_t open_src_r, open_src_nxt;
  pos_t open_dest_r, open_dest_nxt;
  tgt_t tgt_r, tgt_nxt;
  logic open_r, open_nxt;
  logic emit;
  logic out_vld_r, out_vld_nxt;

  logic signed [OUT_BITS-1:0]  src_begin_r, src_stop_r, dest_begin_r, dest_stop_r;
  logic        [TIDX_BITS-1:0] tidx_r;

  assign pop = q_vld && (!out_vld_r || out_ch.ready);

  always_comb begin
    src_pos_nxt   = src_pos_r;
    dest_pos_nxt  = dest_pos_r;
    open_src_nxt  = open_src_r;
    open_dest_nxt = open_dest_r;
    tgt_nxt       = tgt_r;
    open_nxt      = open_r;
    emit          = 1'b0;
    if (pop) begin
      unique case (q_item.op)
        OP_HEADER: begin
          src_pos_nxt   = q_item.src_val;
          dest_pos_nxt  = q_item.dest_val;
          tgt_nxt       = q_item.target;
          open_nxt      = 1'b0;
          open_src_nxt  = '0;
          open_dest_nxt = '0;
        end
        OP_COLUMN: begin
          if (q_item.src_gap || q_item.dest_gap) begin
            emit     = open_r;
            open_nxt = 1'b0;
          end else if (!open_r) begin
            open_nxt      = 1'b1;
            open_src_nxt  = src_pos_r;
            open_dest_nxt = dest_pos_r;
          end
          if (!q_item.src_gap)  src_pos_nxt  = src_pos_r + POS_BITS'(1);
          if (!q_item.dest_gap) dest_pos_nxt = dest_pos_r + POS_BITS'(1);
        end
        OP_END: begin
          emit     = open_r;
          open_nxt = 1'b0;
        end
        default: begin
          open_nxt = open_r;
        end
      endcase
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_ch.ready) out_vld_nxt = 1'b0;
    if (emit)         out_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_pos_r   <= '0;
      dest_pos_r  <= '0;
      open_src_r  <= '0;
      open_dest_r <= '0;
      tgt_r       <= '0;
      open_r      <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      src_pos_r   <= src_pos_nxt;
      dest_pos_r  <= dest_pos_nxt;
      open_src_r  <= open_src_nxt;
      open_dest_r <= open_dest_nxt;
      tgt_r       <= tgt_nxt;
      open_r      <= open_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // closing positions are the row positions before this column advances them
  always_ff @(posedge clk) begin
    if (emit) begin
      src_begin_r  <= to_field(open_src_r);
      src_stop_r   <= to_field(src_pos_r);
      tidx_r       <= TIDX_BITS'(tgt_r);
      dest_begin_r <= to_field(open_dest_r);
      dest_stop_r  <= to_field(dest_pos_r);
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.src_begin    = src_begin_r;
  assign out_ch.src_stop     = src_stop_r;
  assign out_ch.target_index = tidx_r;
  assign out_ch.dest_begin   = dest_begin_r;
  assign out_ch.dest_stop    = dest_stop_r;

  `PAIE_ASSERT_NEXT(a_gap_closes, pop && q_item.op == OP_COLUMN && open_r && (q_item.src_gap || q_item.dest_gap), out_vld_r && !open_r, "gap column did not close interval")
  `PAIE_ASSERT_NEXT(a_header_clears, pop && q_item.op == OP_HEADER, !open_r && src_pos_r == $past(q_item.src_val), "header did not reload state")
  `PAIE_ASSERT_NOW(a_no_overwrite, emit, !out_vld_r || out_ch.ready, "result overwritten while stalled")

endmodule
